[rtl/pal_pkg.sv]
// ============================================================================
// pal_pkg: shared definitions for the positional array list
// Field widths, operation and status codes, and the cell control bundle
// that the list controller sends down the row of storage cells.
// ============================================================================
package pal_pkg;

   // Fixed field widths of the request and response channels.
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   // Default number of list entries.
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOCATE = 2'd2
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

   // What every cell does with its entry in a given cycle.
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cell_cmd_type;

   // pick_match selects the flag a cell raises: a value match inside the
   // list when set, otherwise the cell addressed by the slot number.
   typedef struct packed {
      cell_cmd_type cmd;
      logic         pick_match;
   } cell_ctl_type;

endpackage

[rtl/pal_cell.sv]
// ============================================================================
// pal_cell: one storage cell of the list
// Holds one entry, takes its neighbor's entry on an insert or delete shift,
// and raises a flag for the search tree on a match or a slot hit.
// ============================================================================
module pal_cell #(
   parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  pal_pkg::cell_ctl_type         ctl,
   input  logic [$clog2(CAPACITY)-1:0]   slot,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  logic [pal_pkg::DATA_W-1:0]    key,
   input  logic [pal_pkg::DATA_W-1:0]    left_data,
   input  logic [pal_pkg::DATA_W-1:0]    right_data,
   output logic [pal_pkg::DATA_W-1:0]    data,
   output logic                          flag
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   logic [pal_pkg::DATA_W-1:0] data_ff;
   logic [pal_pkg::DATA_W-1:0] data_in;
   logic                       at_slot;
   logic                       past_slot;

   assign at_slot   = (IW'(CELL_INDEX) == slot);
   assign past_slot = (IW'(CELL_INDEX) > slot);

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         pal_pkg::CMD_INSERT: begin
            if (at_slot) begin
               data_in = key;
            end else if (past_slot) begin
               data_in = left_data;
            end
         end
         pal_pkg::CMD_DELETE: begin
            if (at_slot || past_slot) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign flag = ctl.pick_match ? ((data_ff == key) && (CW'(CELL_INDEX) < count))
                                : at_slot;

endmodule

[rtl/pal_pick_tree.sv]
// ============================================================================
// pal_pick_tree: registered first-flag selection tree
// A binary tree of registered nodes that finds the lowest flagged leaf and
// returns its index and data; each level of nodes is registered, so the
// root settles after a change has passed through every level.
// ============================================================================
module pal_pick_tree #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic [(1 << $clog2(CAPACITY))-1:0]    leaf_flag,
   input  logic [pal_pkg::DATA_W-1:0]            leaf_data [1 << $clog2(CAPACITY)],
   output logic                                  root_hit,
   output logic [$clog2(CAPACITY)-1:0]           root_index,
   output logic [pal_pkg::DATA_W-1:0]            root_data
);

   localparam int IW    = $clog2(CAPACITY);
   localparam int N     = 1 << IW;
   localparam int NODES = N - 1;
   localparam int ALL   = 2 * N - 1;

   logic                       node_hit_ff  [NODES];
   logic [IW-1:0]              node_idx_ff  [NODES];
   logic [pal_pkg::DATA_W-1:0] node_data_ff [NODES];
   logic                       node_hit_in  [NODES];
   logic [IW-1:0]              node_idx_in  [NODES];
   logic [pal_pkg::DATA_W-1:0] node_data_in [NODES];

   logic                       all_hit  [ALL];
   logic [IW-1:0]              all_idx  [ALL];
   logic [pal_pkg::DATA_W-1:0] all_data [ALL];

   // Heap layout: node k has children 2k+1 and 2k+2; leaves follow the nodes.
   always_comb begin
      for (int k = 0; k < NODES; k++) begin
         all_hit[k]  = node_hit_ff[k];
         all_idx[k]  = node_idx_ff[k];
         all_data[k] = node_data_ff[k];
      end
      for (int j = 0; j < N; j++) begin
         all_hit[NODES+j]  = leaf_flag[j];
         all_idx[NODES+j]  = IW'(j);
         all_data[NODES+j] = leaf_data[j];
      end
      for (int k = 0; k < NODES; k++) begin
         node_hit_in[k] = all_hit[2*k+1] | all_hit[2*k+2];
         if (all_hit[2*k+1]) begin
            node_idx_in[k]  = all_idx[2*k+1];
            node_data_in[k] = all_data[2*k+1];
         end else begin
            node_idx_in[k]  = all_idx[2*k+2];
            node_data_in[k] = all_data[2*k+2];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NODES; k++) begin
         node_hit_ff[k]  <= node_hit_in[k];
         node_idx_ff[k]  <= node_idx_in[k];
         node_data_ff[k] <= node_data_in[k];
      end
   end

   assign root_hit   = node_hit_ff[0];
   assign root_index = node_idx_ff[0];
   assign root_data  = node_data_ff[0];

endmodule

[rtl/positional_array_list.sv]
// Insert and rejected requests go from the issue state straight to the
// response; locate and a valid delete first pass the wait state, whose
// length is set by the depth of the registered pick tree. One request at
// a time; the next is taken in the cycle after the response transfer.
// Reset (synchronous, active high) empties the list; storage is not cleared.
// ============================================================================
// positional_array_list: ordered list of signed values with positional edit
// A row of cells holds the list densely packed. Insert and delete shift all
// cells in parallel; locate and the read-out of a deleted entry go through
// a registered tree that picks the lowest flagged cell.
// ============================================================================
module positional_array_list #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pal_pkg::OP_W-1:0]           req_opcode,
   input  logic [pal_pkg::POS_W-1:0]          req_position,
   input  logic signed [pal_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pal_pkg::ST_W-1:0]           rsp_status,
   output logic signed [pal_pkg::DATA_W-1:0]  rsp_removed_value,
   output logic [pal_pkg::POS_W-1:0]          rsp_found_position,
   output logic [pal_pkg::POS_W-1:0]          rsp_list_length,
   output logic                               rsp_is_empty
);

   localparam int IW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY+1);
   localparam int N      = 1 << IW;
   localparam int DW     = pal_pkg::DATA_W;
   localparam int PW     = pal_pkg::POS_W;
   localparam int WW     = ((CW > PW) ? CW : PW) + 1;
   localparam int WAIT_W = $clog2(IW+1);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   pal_pkg::opcode_type      op_ff, op_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [DW-1:0]            val_ff, val_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [WAIT_W-1:0]        wait_ff, wait_in;
   pal_pkg::status_type      status_ff, status_in;
   logic [DW-1:0]            removed_ff, removed_in;
   logic [PW-1:0]            found_ff, found_in;

   pal_pkg::cell_ctl_type    cell_ctl;

   // Range checks are done on a common width wide enough for both operands.
   logic [WW-1:0]            pos_x;
   logic [WW-1:0]            cnt_x;
   logic                     ins_bad;
   logic                     del_bad;
   logic                     list_full;
   logic [PW-1:0]            pos_m1;
   logic [IW+PW-1:0]         slot_wide;
   logic [IW-1:0]            slot;
   logic [CW-1:0]            found_cw;
   logic [CW+PW-1:0]         found_wide;
   logic [CW+PW-1:0]         length_wide;

   wire  [DW-1:0]            cell_data [CAPACITY];
   wire  [N-1:0]             leaf_flag;
   wire  [DW-1:0]            leaf_data [N];
   logic                     root_hit;
   logic [IW-1:0]            root_index;
   logic [DW-1:0]            root_data;

   assign pos_x     = WW'(pos_ff);
   assign cnt_x     = WW'(count_ff);
   assign ins_bad   = (pos_ff == '0) || (pos_x > cnt_x + WW'(1));
   assign del_bad   = (pos_ff == '0) || (pos_x > cnt_x);
   assign list_full = (count_ff == CW'(CAPACITY));

   // The zero-based slot; only used after the position has been checked,
   // so it lies inside the list, or just past its end for an insert there.
   assign pos_m1    = pos_ff - PW'(1);
   assign slot_wide = {{IW{1'b0}}, pos_m1};
   assign slot      = slot_wide[IW-1:0];

   // The tree returns a zero-based index; the response is one-based and
   // reported modulo the 7-bit field.
   assign found_cw   = CW'(root_index) + CW'(1);
   assign found_wide = {{PW{1'b0}}, found_cw};

   // Sequencer: take a request, issue it to the cells, wait on the tree when
   // a search is needed, then hold the response until its transfer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      found_in     = found_ff;
      cell_ctl.cmd = pal_pkg::CMD_HOLD;
      cell_ctl.pick_match = (op_ff == pal_pkg::OP_LOCATE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = pal_pkg::opcode_type'(req_opcode);
               pos_in   = req_position;
               val_in   = req_value;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            removed_in = '0;
            found_in   = '0;
            wait_in    = WAIT_W'(IW);
            case (op_ff)
               pal_pkg::OP_INSERT: begin
                  state_in = S_RESP;
                  if (ins_bad) begin
                     status_in = pal_pkg::ST_BADPOS;
                  end else if (list_full) begin
                     status_in = pal_pkg::ST_FULL;
                  end else begin
                     status_in    = pal_pkg::ST_OK;
                     cell_ctl.cmd = pal_pkg::CMD_INSERT;
                     count_in     = count_ff + CW'(1);
                  end
               end
               pal_pkg::OP_DELETE: begin
                  if (del_bad) begin
                     status_in = pal_pkg::ST_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_WAIT;
                  end
               end
               pal_pkg::OP_LOCATE: begin
                  state_in = S_WAIT;
               end
               default: begin
                  status_in = pal_pkg::ST_BADPOS;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_WAIT: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else begin
               state_in = S_RESP;
               if (op_ff == pal_pkg::OP_DELETE) begin
                  // The tree has picked the addressed cell; close the gap.
                  status_in    = pal_pkg::ST_OK;
                  removed_in   = root_data;
                  cell_ctl.cmd = pal_pkg::CMD_DELETE;
                  count_in     = count_ff - CW'(1);
               end else if (root_hit) begin
                  status_in = pal_pkg::ST_OK;
                  found_in  = found_wide[PW-1:0];
               end else begin
                  status_in = pal_pkg::ST_MISS;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      wait_ff    <= wait_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
   end

   // The row of cells. Cells past the capacity of a non-power-of-two list
   // are tied off as leaves that never flag.
   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i < CAPACITY) begin : g_live
         wire [DW-1:0] left_w;
         wire [DW-1:0] right_w;
         if (i == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_inner_l
            assign left_w = cell_data[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_inner_r
            assign right_w = cell_data[i+1];
         end
         pal_cell #(
            .CAPACITY   (CAPACITY),
            .CELL_INDEX (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .slot       (slot),
            .count      (count_ff),
            .key        (val_ff),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .flag       (leaf_flag[i])
         );
         assign leaf_data[i] = cell_data[i];
      end else begin : g_pad
         assign leaf_flag[i] = 1'b0;
         assign leaf_data[i] = '0;
      end
   end

   pal_pick_tree #(
      .CAPACITY (CAPACITY)
   ) u_tree (
      .clock      (clock),
      .leaf_flag  (leaf_flag),
      .leaf_data  (leaf_data),
      .root_hit   (root_hit),
      .root_index (root_index),
      .root_data  (root_data)
   );

   // The count holds its post-operation value for as long as the response
   // waits, so length and empty come straight from it.
   assign length_wide = {{PW{1'b0}}, count_ff};

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = status_ff;
   assign rsp_removed_value  = removed_ff;
   assign rsp_found_position = found_ff;
   assign rsp_list_length    = length_wide[PW-1:0];
   assign rsp_is_empty       = (count_ff == '0);

`ifndef SYNTHESIS
   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // An insert issued to the cells grows the list by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) && (cell_ctl.cmd == pal_pkg::CMD_INSERT)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   // A full status is only reported for a list at capacity.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == pal_pkg::ST_FULL) |-> count_ff == CW'(CAPACITY))
      else $error("full status on a list below capacity");

   // A successful locate always points inside the list.
   a_found_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (op_ff == pal_pkg::OP_LOCATE) && (status_ff == pal_pkg::ST_OK)
      |-> (found_ff != '0) && (CW'(root_index) < count_ff))
      else $error("locate hit outside the list");
`endif

endmodule

[sim/positional_array_list_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// positional_array_list_tb: self-checking bench for the positional array list
// Drives insert, delete, locate and unused opcodes over valid/ready with
// random gaps on both channels, predicts responses from a shadow list or a
// typed table row, and compares each response transfer field by field in order.
// ============================================================================
module positional_array_list_tb;

   localparam int CLOCK_PERIOD   = 20;
   localparam int LIST_DEPTH     = pal_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 750;
   // Allows a margin over the longest locate/delete.
   localparam int DRAIN_CYCLES   = 24;
   // Slowest legal transfer: the longest sender gap plus the longest receiver
   // stall plus the block's own time. The limit is many times that.
   localparam int WATCHDOG_LIMIT = 2000;

   // Opcode 3 is not an operation; the block must reject it.
   localparam logic [pal_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // One response as it leaves the block.
   typedef struct packed {
      pal_pkg::status_type                status;
      logic signed [pal_pkg::DATA_W-1:0]  removed;
      logic [pal_pkg::POS_W-1:0]          found;
      logic [pal_pkg::POS_W-1:0]          length;
      logic                               empty;
   } list_result_type;

   // One row of the directed table. Where typed is set, the expected
   // response is written out by hand; elsewhere the shadow list decides.
   typedef struct packed {
      logic [pal_pkg::OP_W-1:0]           op;
      logic [pal_pkg::POS_W-1:0]          pos;
      logic signed [pal_pkg::DATA_W-1:0]  val;
      logic                               typed;
      list_result_type                    want;
   } directed_row_type;

   typedef enum int {
      LOAD_GROW,
      LOAD_SHRINK,
      LOAD_BALANCED
   } load_mode_type;

   localparam int DIRECTED_ROWS = 24;

   localparam logic signed [pal_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [pal_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [pal_pkg::DATA_W-1:0] VAL_NEG = -32'sd1;

   // The walk starts on an empty list: first the rejections that an empty
   // list must give, then both extremes of the value range at the front and
   // minus one at the end, searches for each of them, a duplicate to prove the
   // first match wins, bad delete positions, and a drain back to empty.
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{pal_pkg::OP_LOCATE, 7'd0,   32'sd0,  1'b1,
        '{pal_pkg::ST_MISS,   32'sd0, 7'd0, 7'd0, 1'b1}},
      '{pal_pkg::OP_DELETE, 7'd1,   32'sd0,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd0, 1'b1}},
      '{pal_pkg::OP_INSERT, 7'd0,   32'sd5,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd0, 1'b1}},
      '{pal_pkg::OP_INSERT, 7'd2,   32'sd5,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd0, 1'b1}},
      '{OP_UNUSED,          7'd1,   32'sd5,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd0, 1'b1}},
      '{pal_pkg::OP_INSERT, 7'd1,   VAL_MAX, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd0, 7'd1, 1'b0}},
      '{pal_pkg::OP_INSERT, 7'd1,   VAL_MIN, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd0, 7'd2, 1'b0}},
      '{pal_pkg::OP_INSERT, 7'd3,   VAL_NEG, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd0, 7'd3, 1'b0}},
      '{pal_pkg::OP_INSERT, 7'd127, VAL_NEG, 1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd3, 1'b0}},
      '{pal_pkg::OP_LOCATE, 7'd0,   VAL_MIN, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd1, 7'd3, 1'b0}},
      '{pal_pkg::OP_LOCATE, 7'd127, VAL_NEG, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd3, 7'd3, 1'b0}},
      '{pal_pkg::OP_LOCATE, 7'd0,   VAL_MAX, 1'b1,
        '{pal_pkg::ST_OK,     32'sd0, 7'd2, 7'd3, 1'b0}},
      '{pal_pkg::OP_LOCATE, 7'd0,   32'sd0,  1'b1,
        '{pal_pkg::ST_MISS,   32'sd0, 7'd0, 7'd3, 1'b0}},
      '{pal_pkg::OP_INSERT, 7'd2,   VAL_MAX, 1'b0, '0},
      '{pal_pkg::OP_LOCATE, 7'd0,   VAL_MAX, 1'b0, '0},
      '{pal_pkg::OP_DELETE, 7'd0,   32'sd0,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd4, 1'b0}},
      '{pal_pkg::OP_DELETE, 7'd5,   32'sd0,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd4, 1'b0}},
      '{pal_pkg::OP_DELETE, 7'd4,   32'sd0,  1'b0, '0},
      '{pal_pkg::OP_DELETE, 7'd1,   32'sd0,  1'b0, '0},
      '{pal_pkg::OP_INSERT, 7'd4,   32'sd9,  1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd2, 1'b0}},
      '{OP_UNUSED,          7'd127, VAL_NEG, 1'b1,
        '{pal_pkg::ST_BADPOS, 32'sd0, 7'd0, 7'd2, 1'b0}},
      '{pal_pkg::OP_DELETE, 7'd2,   32'sd0,  1'b0, '0},
      '{pal_pkg::OP_DELETE, 7'd1,   32'sd0,  1'b0, '0},
      '{pal_pkg::OP_LOCATE, 7'd0,   VAL_MAX, 1'b1,
        '{pal_pkg::ST_MISS,   32'sd0, 7'd0, 7'd0, 1'b1}}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [pal_pkg::OP_W-1:0]           req_opcode = '0;
   logic [pal_pkg::POS_W-1:0]          req_position = '0;
   logic signed [pal_pkg::DATA_W-1:0]  req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [pal_pkg::ST_W-1:0]           rsp_status;
   logic signed [pal_pkg::DATA_W-1:0]  rsp_removed_value;
   logic [pal_pkg::POS_W-1:0]          rsp_found_position;
   logic [pal_pkg::POS_W-1:0]          rsp_list_length;
   logic                               rsp_is_empty;

   // Shadow of the list contents and length, updated at each request transfer.
   logic signed [pal_pkg::DATA_W-1:0]  shadow_list [LIST_DEPTH];
   int                                 shadow_count = 0;

   // Responses still owed by the block, oldest first.
   list_result_type                    pending_results [$];
   list_result_type                    head_result;

   int                                 mismatch_count = 0;
   int                                 response_index = 0;
   int                                 idle_cycles = 0;
   int                                 rsp_stall_left = 0;
   bit                                 steady_run = 1'b0;

   positional_array_list #(
      .CAPACITY(LIST_DEPTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_is_empty       (rsp_is_empty)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Applies one operation to the shadow list and returns the response the
   // block owes for it. The range test on an insert comes ahead of the
   // full test, so a far position on a full list reads as a bad position.
   function automatic list_result_type apply_list_op(
         input logic [pal_pkg::OP_W-1:0] op,
         input logic [pal_pkg::POS_W-1:0] pos,
         input logic signed [pal_pkg::DATA_W-1:0] val);
      list_result_type r;
      int              slot;
      int              at;
      r = '{status: pal_pkg::ST_OK, removed: '0, found: '0, length: '0, empty: 1'b0};
      at = int'(pos);
      case (op)
         pal_pkg::OP_INSERT: begin
            if (at == 0 || at > shadow_count + 1) begin
               r.status = pal_pkg::ST_BADPOS;
            end else if (shadow_count >= LIST_DEPTH) begin
               r.status = pal_pkg::ST_FULL;
            end else begin
               for (slot = shadow_count; slot >= at; slot--)
                  shadow_list[slot] = shadow_list[slot - 1];
               shadow_list[at - 1] = val;
               shadow_count++;
            end
         end
         pal_pkg::OP_DELETE: begin
            if (at == 0 || at > shadow_count) begin
               r.status = pal_pkg::ST_BADPOS;
            end else begin
               r.removed = shadow_list[at - 1];
               for (slot = at; slot < shadow_count; slot++)
                  shadow_list[slot - 1] = shadow_list[slot];
               // The slot freed at the old end goes back to zero.
               shadow_list[shadow_count - 1] = '0;
               shadow_count--;
            end
         end
         pal_pkg::OP_LOCATE: begin
            // Only live entries are searched, and the lowest match wins.
            r.status = pal_pkg::ST_MISS;
            for (slot = 0; slot < shadow_count; slot++) begin
               if (shadow_list[slot] == val) begin
                  r.found  = pal_pkg::POS_W'(slot + 1);
                  r.status = pal_pkg::ST_OK;
                  break;
               end
            end
         end
         default: begin
            r.status = pal_pkg::ST_BADPOS;
         end
      endcase
      r.length = pal_pkg::POS_W'(shadow_count);
      r.empty  = (shadow_count == 0);
      return r;
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one. During a
   // steady run there are no gaps at all.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_run)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Values lean toward a small set so that duplicates are common, with the
   // range extremes mixed in.
   function automatic logic signed [pal_pkg::DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll < 2)
         return pal_pkg::DATA_W'($signed($urandom_range(0, 4)) - 2);
      if (roll == 2)
         return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
      return $urandom();
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("ERROR %0t ns response %0d: %s expected %0d got %0d",
               $time, response_index, what, want, got);
      mismatch_count++;
   endtask

   // Presents one request, holds it until the transfer, then books the
   // response that it owes. A typed row books its hand-written response.
   task automatic send_request(input logic [pal_pkg::OP_W-1:0] op,
                               input logic [pal_pkg::POS_W-1:0] pos,
                               input logic signed [pal_pkg::DATA_W-1:0] val,
                               input logic use_typed,
                               input list_result_type typed_result);
      int              gap;
      list_result_type predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_list_op(op, pos, val);
      pending_results.push_back(use_typed ? typed_result : predicted);
   endtask

   // Receiver side: stalls of random length, with no stalls while the
   // sender is in a steady run.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady_run && $urandom_range(0, 3) == 0)
            rsp_stall_left = pick_gap();
      end
   end

   // Each response transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending, status", -1, rsp_status);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_status !== head_result.status)
               report_mismatch("status", head_result.status, rsp_status);
            if (rsp_removed_value !== head_result.removed)
               report_mismatch("removed_value", head_result.removed, rsp_removed_value);
            if (rsp_found_position !== head_result.found)
               report_mismatch("found_position", head_result.found, rsp_found_position);
            if (rsp_list_length !== head_result.length)
               report_mismatch("list_length", head_result.length, rsp_list_length);
            if (rsp_is_empty !== head_result.empty)
               report_mismatch("is_empty", head_result.empty, rsp_is_empty);
         end
         response_index++;
      end
   end

   // The watchdog restarts on every transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      load_mode_type                      mode;
      int                                 row;
      int                                 random_sent;
      int                                 epoch;
      int                                 epoch_len;
      int                                 epoch_target;
      int                                 tail;
      int                                 roll;
      bit                                 epoch_done;
      logic [pal_pkg::OP_W-1:0]           op;
      logic [pal_pkg::POS_W-1:0]          pos;
      logic signed [pal_pkg::DATA_W-1:0]  val;

      foreach (shadow_list[i])
         shadow_list[i] = '0;
      random_sent = 0;
      epoch = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++)
         send_request(directed_table[row].op, directed_table[row].pos,
                      directed_table[row].val, directed_table[row].typed,
                      directed_table[row].want);

      // Random traffic in epochs. A grow epoch runs until the list is full
      // and then keeps pushing inserts against it; a shrink epoch drains the
      // list and then pokes at the empty list. The very first epoch grows so
      // that the full case is always reached.
      while (random_sent < RANDOM_ITEMS) begin
         if (epoch == 0)
            mode = LOAD_GROW;
         else
            mode = load_mode_type'($urandom_range(0, 2));
         steady_run   = ($urandom_range(0, 3) == 0);
         epoch_target = $urandom_range(40, 120);
         epoch_len    = 0;
         tail         = 0;
         epoch_done   = 1'b0;
         while (!epoch_done) begin
            roll = $urandom_range(0, 99);
            // Split of insert / delete / locate / noise for each mode.
            case (mode)
               LOAD_GROW:   roll = (roll < 70) ? 0 : (roll < 80) ? 1 : (roll < 95) ? 2 : 3;
               LOAD_SHRINK: roll = (roll < 70) ? 1 : (roll < 80) ? 0 : (roll < 95) ? 2 : 3;
               default:     roll = (roll < 35) ? 0 : (roll < 65) ? 1 : (roll < 90) ? 2 : 3;
            endcase
            val = pick_value();
            case (roll)
               0: begin
                  op  = pal_pkg::OP_INSERT;
                  pos = pal_pkg::POS_W'($urandom_range(1, shadow_count + 1));
               end
               1: begin
                  op  = pal_pkg::OP_DELETE;
                  pos = (shadow_count == 0) ? pal_pkg::POS_W'(1)
                                            : pal_pkg::POS_W'($urandom_range(1, shadow_count));
               end
               2: begin
                  // Mostly search for a live entry; the rest are likely misses.
                  op  = pal_pkg::OP_LOCATE;
                  pos = pal_pkg::POS_W'($urandom_range(0, 127));
                  if (shadow_count > 0 && $urandom_range(0, 9) < 7)
                     val = shadow_list[$urandom_range(0, shadow_count - 1)];
               end
               default: begin
                  op  = pal_pkg::OP_W'($urandom_range(0, 3));
                  pos = pal_pkg::POS_W'($urandom_range(0, 127));
                  val = $urandom();
               end
            endcase
            send_request(op, pos, val, 1'b0, '0);
            random_sent++;
            epoch_len++;
            case (mode)
               LOAD_GROW: begin
                  if (shadow_count == LIST_DEPTH)
                     tail++;
                  epoch_done = (tail >= 6) || (epoch_len >= 300);
               end
               LOAD_SHRINK: begin
                  if (shadow_count == 0)
                     tail++;
                  epoch_done = (tail >= 4) || (epoch_len >= 300);
               end
               default: begin
                  epoch_done = (epoch_len >= epoch_target);
               end
            endcase
            // The run stops at the item budget even in the middle of an epoch.
            if (random_sent >= RANDOM_ITEMS)
               epoch_done = 1'b1;
         end
         epoch++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      steady_run = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
